// ===== sv/tdpt_pkg.sv =====
// Shared types for the trial division prime test.
// Command and status bundles between controller and datapath; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_REM,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request number, divisor = 3, square = 9
    logic div_start;   // start remainder of number by divisor
    logic div_step;    // one restoring step
    logic next_div;    // divisor += 2, square updated
    logic set_result;  // latch result_val
    logic result_val;
    logic push_out;    // move result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_small_prime;  // number is 2 or 3
    logic is_trivial_no;   // number below 5 or even
    logic sq_gt_n;         // divisor squared exceeds number
    logic div_done;        // all remainder steps taken
    logic rem_zero;        // remainder is zero
    logic out_busy;        // output register full and not taken
  } status_t;

endpackage

`default_nettype wire

// ===== sv/tdpt_ctrl.sv =====
// Controller FSM for the trial division prime test.
// Depends on tdpt_pkg (state_e, cmd_t, status_t).
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  tdpt_pkg::status_t status_i,
  output tdpt_pkg::cmd_t    cmd_o
);

  tdpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_CHECK: begin
        if (status_i.is_small_prime) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_val = 1'b1;
          state_d          = tdpt_pkg::ST_DONE;
        end else if (status_i.is_trivial_no) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_val = 1'b0;
          state_d          = tdpt_pkg::ST_DONE;
        end else if (status_i.sq_gt_n) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_val = 1'b1;
          state_d          = tdpt_pkg::ST_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = tdpt_pkg::ST_REM;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      tdpt_pkg::ST_REM: begin
        if (status_i.rem_zero) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_val = 1'b0;
          state_d          = tdpt_pkg::ST_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.push_out = 1'b1;
          state_d        = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tdpt_dp.sv =====
// Datapath for the trial division prime test: number, divisor, running square,
// bit-serial restoring remainder unit and output register. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_dp #(
  parameter int NUMBER_BITS = 31
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [NUMBER_BITS-1:0] number_i,
  input  tdpt_pkg::cmd_t        cmd_i,
  output tdpt_pkg::status_t     status_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  is_prime_o
);

  localparam int SqBits  = NUMBER_BITS + 2;
  localparam int CntBits = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] n_q, d_q, sh_q;
  logic [SqBits-1:0]      sq_q;
  logic [NUMBER_BITS:0]   r_q;
  logic [CntBits-1:0]     cnt_q;
  logic                   result_q;
  logic                   out_valid_q;
  logic                   out_data_q;

  logic [NUMBER_BITS:0]   r_shift;
  logic [NUMBER_BITS:0]   d_ext;

  assign d_ext   = {1'b0, d_q};
  assign r_shift = {r_q[NUMBER_BITS-1:0], sh_q[NUMBER_BITS-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q  <= number_i;
      d_q  <= NUMBER_BITS'(3);
      sq_q <= SqBits'(9);
    end else if (cmd_i.next_div) begin
      d_q  <= d_q + NUMBER_BITS'(2);
      // (d+2)^2 = d^2 + 4d + 4
      sq_q <= sq_q + {d_q, 2'b00} + SqBits'(4);
    end
    if (cmd_i.div_start) begin
      r_q   <= '0;
      sh_q  <= n_q;
      cnt_q <= CntBits'(NUMBER_BITS);
    end else if (cmd_i.div_step) begin
      r_q   <= (r_shift >= d_ext) ? (r_shift - d_ext) : r_shift;
      sh_q  <= {sh_q[NUMBER_BITS-2:0], 1'b0};
      cnt_q <= cnt_q - CntBits'(1);
    end
    if (cmd_i.set_result) begin
      result_q <= cmd_i.result_val;
    end
    if (cmd_i.push_out) begin
      out_data_q <= result_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.is_small_prime = (n_q == NUMBER_BITS'(2)) || (n_q == NUMBER_BITS'(3));
    status_o.is_trivial_no  = (n_q < NUMBER_BITS'(5)) || !n_q[0];
    status_o.sq_gt_n        = sq_q > {2'b00, n_q};
    status_o.div_done       = (cnt_q == '0);
    status_o.rem_zero       = (r_q == '0);
    status_o.out_busy       = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/trial_division_prime_test.sv =====
// Top level of the trial division prime test: stream ports, controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_dp.
//
// Usage:
//   Slave stream (s_axis_*) takes one request: the number to test in the low
//   NUMBER_BITS bits of tdata; upper tdata bits are ignored.
//   Master stream (m_axis_*) returns one result per request: is_prime in bit 0.
//   Requests are taken one at a time. tready is high only while the engine is
//   idle; a new request may be taken while the previous result still waits
//   in the output register.
// Sequence:
//   Numbers below 9 and even numbers: decided in the check state, then the
//   result goes through the done state to the output register and tvalid.
//   Odd numbers of 9 or more: each odd trial divisor d with d*d <= number
//   takes a check, a bit-serial remainder (one bit per cycle) and a test;
//   the result is then handed off through the done state. Testing stops
//   at the first zero remainder.
// Next request: tready returns the cycle after the result is pushed, so the
//   next request is taken only after the previous one is finished.
// Reset: rst_ni (async, active low) returns the controller to idle and drops
//   m_axis_tvalid; an in-flight request is lost.
// Stall: a result held by the receiver stays in the output register; a
//   finished next result waits in the engine until that slot frees.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test #(
  parameter int NUMBER_BITS = 31
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // slave stream: request
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [((NUMBER_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [NUMBER_BITS-1:0] number
  // master stream: result
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [7:0]                        m_axis_tdata   // [0] is_prime, rest zero
);

  tdpt_pkg::cmd_t    cmd;
  tdpt_pkg::status_t status;
  logic              is_prime;

  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdpt_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (s_axis_tdata[NUMBER_BITS-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .is_prime_o  (is_prime)
  );

  assign m_axis_tdata = {7'b0, is_prime};

endmodule

`default_nettype wire
